>>> design/assert_macros.svh
// Assertion macros shared by the heading/thrust controller RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PDH_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pdh check failed");
`define PDH_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pdh implication failed");
`else
`define PDH_CHECK(lbl, prop)
`define PDH_IMPLY(lbl, pre, post)
`endif

`endif

>>> design/pdh_pkg.sv
// Shared types, constants and the arctangent table for the heading/thrust controller.
// No dependencies.
`default_nettype none

package pdh_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int XW = 37;     // CORDIC x/y datapath
    localparam int ZW = 36;     // Q30 angle datapath

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 37'sd652032874;
    localparam logic [63:0] PROD_LIMIT = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic is_div;
    } ssu_cmd_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            5'd18: r = 30'd4096;
            5'd19: r = 30'd2048;
            5'd20: r = 30'd1024;
            5'd21: r = 30'd512;
            5'd22: r = 30'd256;
            5'd23: r = 30'd128;
            5'd24: r = 30'd64;
            5'd25: r = 30'd32;
            5'd26: r = 30'd16;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            5'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/pdh_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing beyond the clock.
`default_nettype none

module pdh_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [63:0]      prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> design/pdh_ssu.sv
// Shift-subtract unit: bit-serial square root (64-bit radicand) and
// restoring division (48-bit numerator by 32-bit divisor). Uses pdh_pkg.
`default_nettype none

module pdh_ssu
    import pdh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ssu_cmd_t    cmd,
    input  wire logic [63:0] operand,   // radicand, or numerator left-aligned
    input  wire logic [31:0] divisor,
    output logic [47:0]      result,
    output logic             done
);

    logic [34:0] rem_reg, rem_next;
    logic [63:0] sh_reg, sh_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        is_div_reg;
    logic        done_reg, done_next;
    logic [34:0] cand, trial, diff;
    logic        ge;

    always_comb
    begin
        cand  = is_div_reg ? {2'b00, rem_reg[31:0], sh_reg[63]}
                           : {rem_reg[32:0], sh_reg[63:62]};
        trial = is_div_reg ? {3'b000, den_reg} : {1'b0, q_reg[31:0], 2'b01};
        ge    = (cand >= trial);
        diff  = cand - trial;

        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next = '0;
            sh_next  = operand;
            q_next   = '0;
            cnt_next = cmd.is_div ? 6'd48 : 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_next  = ge ? diff : cand;
            q_next    = {q_reg[46:0], ge};
            sh_next   = is_div_reg ? {sh_reg[62:0], 1'b0} : {sh_reg[61:0], 2'b00};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        if (cmd.start)
        begin
            is_div_reg <= cmd.is_div;
            den_reg    <= divisor;
        end
    end

    assign result = q_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> design/pdh_cordic.sv
// One-step-per-cycle CORDIC, vectoring (atan2) or rotation (sin/cos) mode.
// Uses pdh_pkg for widths, step count and the arctangent table.
`default_nettype none

module pdh_cordic
    import pdh_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cordic_cmd_t          cmd,
    input  wire logic signed [XW-1:0] x0,
    input  wire logic signed [XW-1:0] y0,
    input  wire logic signed [ZW-1:0] z0,
    output logic signed [XW-1:0]      x,
    output logic signed [XW-1:0]      y,
    output logic signed [ZW-1:0]      z,
    output logic                      done
);

    localparam int IDX_W = (CSTEPS > 1) ? $clog2(CSTEPS) : 1;

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next, at;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 vec_reg;
    logic                 plus, active;

    always_comb
    begin
        xs     = x_reg >>> idx_reg;
        ys     = y_reg >>> idx_reg;
        at     = ZW'(atan_q30(5'(idx_reg)));
        // vectoring drives y to zero; rotation drives z to zero
        plus   = vec_reg ? y_reg[XW-1] : !z_reg[ZW-1];
        active = vec_reg ? (y_reg != '0) : 1'b1;

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            x_next    = x0;
            y_next    = y0;
            z_next    = z0;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (active)
            begin
                if (plus)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(CSTEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.start)
        begin
            vec_reg <= cmd.vectoring;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> design/pd_heading_thrust_controller.sv
// Planar PD position controller: sequencer, gain registers and output stage.
// Uses pdh_pkg, pdh_mul, pdh_ssu, pdh_cordic and assert_macros.svh.
//
// Usage:
//   Input channel (item_valid / item_stall) carries target and current
//   position plus elapsed time. Output channel (result_valid / result_stall)
//   returns thrust, heading and yaw quaternion z/w, one result per item.
//   Gains are written over the APB port at 0x0 (Kp) and 0x4 (Kd).
//   Each item runs through the squaring multiplies, the square root (skipped
//   when the sum of squares overflows), the rate division (skipped when dt is
//   zero), the gain multiplies and two CORDIC passes (vectoring, rotation).
//   A single multiplier, shift-subtract unit and CORDIC are reused in turn,
//   so one item is in flight at a time and item_stall stays high until done.
//   The finished result sits in an output register; the next item may be
//   taken while it waits. If the receiver keeps stalling, the following
//   result is held in the sequencer until the output register frees up.
//   Reset clears both gains, the stored distance error and all control
//   state; the block is ready straight out of reset.
`default_nettype none

`include "assert_macros.svh"

module pd_heading_thrust_controller
    import pdh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] current_x,
    input  wire logic signed [31:0] current_y,
    input  wire logic [31:0]        elapsed_time,
    // output channel
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [16:0]      thrust_cmd,
    output logic signed [16:0]      heading_cmd,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DE    = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MP    = 4'd7;
    localparam logic [3:0] S_ML    = 4'd8;
    localparam logic [3:0] S_MH    = 4'd9;
    localparam logic [3:0] S_MD    = 4'd10;
    localparam logic [3:0] S_THR   = 4'd11;
    localparam logic [3:0] S_VEC   = 4'd12;
    localparam logic [3:0] S_ROTGO = 4'd13;
    localparam logic [3:0] S_ROT   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    localparam logic ADDR_KP = 1'b0;

    function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + XW'(16384)) >>> 15;
        if (r > XW'(32767))
        begin
            return 16'sh7fff;
        end
        else if (r < -XW'(32768))
        begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    logic [3:0]          state_reg, state_next;
    logic signed [31:0]  kp_reg, kd_reg;
    logic [31:0]         last_reg, last_next;
    logic signed [32:0]  dx_reg, dy_reg;
    logic [31:0]         dt_reg;
    logic [63:0]         sx_reg;
    logic [31:0]         e_reg, e_next;
    logic                de_neg_reg, de_neg_next;
    logic [47:0]         rmag_reg, rmag_next;
    logic signed [63:0]  pterm_reg, pterm_next;
    logic [63:0]         dlo_reg;
    logic signed [63:0]  dterm_reg, dterm_next;
    logic signed [16:0]  thr_reg, thr_next;
    logic signed [ZW-1:0] h_reg, h_next;
    logic                neg_reg, neg_next;
    logic signed [16:0]  hq_reg, hq_next;
    logic signed [15:0]  qz_reg, qz_next, qw_reg, qw_next;

    logic                rv_reg, rv_next;
    logic signed [16:0]  out_thr_reg, out_hd_reg;
    logic signed [15:0]  out_qz_reg, out_qw_reg;
    logic                load_out;

    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;
    ssu_cmd_t            ssu_cmd;
    logic [63:0]         ssu_op;
    logic [47:0]         ssu_res;
    logic                ssu_done;
    cordic_cmd_t         cor_cmd;
    logic signed [XW-1:0] cx0, cy0, cx, cy;
    logic signed [ZW-1:0] cz0, cz;
    logic                cor_done;

    logic [31:0]         absdx, absdy, abskp, abskd, demag;
    logic signed [32:0]  kp_ext, kd_ext, de;
    logic [64:0]         sq_sum, dfull;
    logic [63:0]         psat, dsat;
    logic signed [63:0]  tsum;
    logic signed [47:0]  tshift;
    logic signed [ZW-1:0] zc, ahalf;
    logic signed [18:0]  hq_wide;
    logic                cfg_wr, accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == ADDR_KP) ? kp_reg : kd_reg;
    assign accept  = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);

    assign kp_ext = {kp_reg[31], kp_reg};
    assign kd_ext = {kd_reg[31], kd_reg};
    assign abskp  = 32'(kp_ext[32] ? -kp_ext : kp_ext);
    assign abskd  = 32'(kd_ext[32] ? -kd_ext : kd_ext);
    assign absdx  = 32'(dx_reg[32] ? -dx_reg : dx_reg);
    assign absdy  = 32'(dy_reg[32] ? -dy_reg : dy_reg);

    pdh_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pdh_ssu u_ssu (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ssu_cmd),
        .operand (ssu_op),
        .divisor (dt_reg),
        .result  (ssu_res),
        .done    (ssu_done)
    );

    pdh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .x0    (cx0),
        .y0    (cy0),
        .z0    (cz0),
        .x     (cx),
        .y     (cy),
        .z     (cz),
        .done  (cor_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        e_next      = e_reg;
        de_neg_next = de_neg_reg;
        rmag_next   = rmag_reg;
        pterm_next  = pterm_reg;
        dterm_next  = dterm_reg;
        thr_next    = thr_reg;
        h_next      = h_reg;
        neg_next    = neg_reg;
        hq_next     = hq_reg;
        qz_next     = qz_reg;
        qw_next     = qw_reg;
        load_out    = 1'b0;

        mul_a   = '0;
        mul_b   = '0;
        ssu_cmd = '0;
        ssu_op  = '0;
        cor_cmd = '0;
        cx0     = '0;
        cy0     = '0;
        cz0     = '0;

        sq_sum = {1'b0, sx_reg} + {1'b0, prod};
        de     = $signed({1'b0, e_reg}) - $signed({1'b0, last_reg});
        demag  = 32'(de[32] ? -de : de);
        psat   = (prod > PROD_LIMIT) ? PROD_LIMIT : prod;
        dfull  = {3'b000, prod[29:0], 32'b0} + {1'b0, dlo_reg};
        dsat   = ((prod[63:30] != '0) || (dfull > {1'b0, PROD_LIMIT}))
                 ? PROD_LIMIT : dfull[63:0];
        tsum   = pterm_reg + dterm_reg;
        if (tsum >= 64'sh8000_0000)
        begin
            tsum = 64'sh8000_0000;
        end
        else if (tsum <= -64'sh8000_0000)
        begin
            tsum = -64'sh8000_0000;
        end
        tshift = 48'((tsum + 64'sd32768) >>> 16);
        zc     = cz;
        if (zc > PI_Q30)
        begin
            zc = PI_Q30;
        end
        else if (zc < -PI_Q30)
        begin
            zc = -PI_Q30;
        end
        ahalf   = h_reg >>> 1;
        hq_wide = 19'((h_reg + ZW'(65536)) >>> 17);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                mul_a      = absdx;
                mul_b      = absdx;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                mul_a      = absdy;
                mul_b      = absdy;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sq_sum[64])
                begin
                    e_next     = '1;
                    state_next = S_DE;
                end
                else
                begin
                    ssu_cmd.start = 1'b1;
                    ssu_op        = sq_sum[63:0];
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (ssu_done)
                begin
                    e_next     = ssu_res[31:0];
                    state_next = S_DE;
                end
            end
            S_DE:
            begin
                last_next   = e_reg;
                de_neg_next = de[32];
                if (dt_reg == '0)
                begin
                    rmag_next  = '0;
                    state_next = S_MP;
                end
                else
                begin
                    ssu_cmd.start  = 1'b1;
                    ssu_cmd.is_div = 1'b1;
                    ssu_op         = {demag, 32'b0};
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ssu_done)
                begin
                    rmag_next  = ssu_res;
                    state_next = S_MP;
                end
            end
            S_MP:
            begin
                mul_a      = abskp;
                mul_b      = e_reg;
                state_next = S_ML;
            end
            S_ML:
            begin
                pterm_next = kp_reg[31] ? -$signed(psat) : $signed(psat);
                mul_a      = abskd;
                mul_b      = rmag_reg[31:0];
                state_next = S_MH;
            end
            S_MH:
            begin
                mul_a      = abskd;
                mul_b      = {16'b0, rmag_reg[47:32]};
                state_next = S_MD;
            end
            S_MD:
            begin
                dterm_next = (kd_reg[31] ^ de_neg_reg) ? -$signed(dsat) : $signed(dsat);
                state_next = S_THR;
            end
            S_THR:
            begin
                thr_next          = 17'(tshift);
                cor_cmd.start     = 1'b1;
                cor_cmd.vectoring = 1'b1;
                if (dx_reg[32])
                begin
                    cx0 = -XW'(dx_reg);
                    cy0 = -XW'(dy_reg);
                    cz0 = dy_reg[32] ? -PI_Q30 : PI_Q30;
                end
                else
                begin
                    cx0 = XW'(dx_reg);
                    cy0 = XW'(dy_reg);
                end
                state_next = S_VEC;
            end
            S_VEC:
            begin
                if (cor_done)
                begin
                    h_next = zc;
                    // facing away: turn around and reverse thrust
                    if (zc >= HALF_PI_Q30 || zc <= -HALF_PI_Q30)
                    begin
                        h_next   = zc + PI_Q30;
                        thr_next = -thr_reg;
                    end
                    state_next = S_ROTGO;
                end
            end
            S_ROTGO:
            begin
                if (hq_wide < -19'sd12868)
                begin
                    hq_next = -17'sd12868;
                end
                else if (hq_wide > 19'sd51472)
                begin
                    hq_next = 17'sd51472;
                end
                else
                begin
                    hq_next = 17'(hq_wide);
                end
                cor_cmd.start = 1'b1;
                cx0           = GAIN_Q30;
                neg_next      = 1'b0;
                cz0           = ahalf;
                if (ahalf > HALF_PI_Q30)
                begin
                    cz0      = ahalf - PI_Q30;
                    neg_next = 1'b1;
                end
                else if (ahalf < -HALF_PI_Q30)
                begin
                    cz0      = ahalf + PI_Q30;
                    neg_next = 1'b1;
                end
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (cor_done)
                begin
                    qz_next    = to_q15(neg_reg ? -cy : cy);
                    qw_next    = to_q15(neg_reg ? -cx : cx);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rv_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rv_next = load_out || (rv_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            kp_reg    <= '0;
            kd_reg    <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            last_reg  <= last_next;
            if (cfg_wr)
            begin
                if (paddr[2] == ADDR_KP)
                begin
                    kp_reg <= pwdata;
                end
                else
                begin
                    kd_reg <= pwdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= 33'(target_x) - 33'(current_x);
            dy_reg <= 33'(target_y) - 33'(current_y);
            dt_reg <= elapsed_time;
        end
        if (state_reg == S_SQY)
        begin
            sx_reg <= prod;
        end
        if (state_reg == S_MH)
        begin
            dlo_reg <= prod;
        end
        e_reg      <= e_next;
        de_neg_reg <= de_neg_next;
        rmag_reg   <= rmag_next;
        pterm_reg  <= pterm_next;
        dterm_reg  <= dterm_next;
        thr_reg    <= thr_next;
        h_reg      <= h_next;
        neg_reg    <= neg_next;
        hq_reg     <= hq_next;
        qz_reg     <= qz_next;
        qw_reg     <= qw_next;
        if (load_out)
        begin
            out_thr_reg <= thr_reg;
            out_hd_reg  <= hq_reg;
            out_qz_reg  <= qz_reg;
            out_qw_reg  <= qw_reg;
        end
    end

    assign result_valid = rv_reg;
    assign thrust_cmd   = out_thr_reg;
    assign heading_cmd  = out_hd_reg;
    assign quat_z       = out_qz_reg;
    assign quat_w       = out_qw_reg;

    `PDH_IMPLY(a_thrust_range, result_valid,
        thrust_cmd >= -17'sd32768 && thrust_cmd <= 17'sd32768)
    `PDH_IMPLY(a_heading_range, result_valid,
        heading_cmd >= -17'sd12868 && heading_cmd <= 17'sd51472)
    `PDH_IMPLY(a_ssu_done_state, ssu_done, state_reg == S_SQRT || state_reg == S_DIV)
    `PDH_IMPLY(a_cordic_done_state, cor_done, state_reg == S_VEC || state_reg == S_ROT)
    `PDH_CHECK(a_no_overwrite, !(load_out && rv_reg && result_stall))

endmodule

`default_nettype wire
